// ----- rtl/cpmsc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpmsc_pkg: shared types and helpers
// Saturation, clamp and the request and response types of the serial multiplier.
// ----------------------------------------------------------------------------
package cpmsc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned GainW = 24;
  localparam int unsigned TgtW  = 26;
  localparam int unsigned DutyW = 16;
  localparam int unsigned RawW  = 22;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 26;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_SPEED_KP  = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_SPEED_KI  = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_SPEED_IL  = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_CMD_LIM   = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_CUR_KP    = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_CUR_KI    = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_CUR_IL    = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_TARGET    = 4'd7;

  typedef struct packed {
    logic                    start;
    logic signed [DataW-1:0] a;    // signed operand
    logic [DataW-1:0]        b;    // unsigned gain
  } mul_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [DataW-1:0] res;
  } mul_rsp_t;

  // saturate a grown sum to 32 bits
  function automatic logic signed [DataW-1:0] sat34(input logic signed [33:0] x);
    logic signed [33:0] mx;
    logic signed [33:0] mn;
    begin
      mx = 34'sh0_7FFF_FFFF;
      mn = -34'sh0_8000_0000;
      if (x > mx) sat34 = 32'sh7FFF_FFFF;
      else if (x < mn) sat34 = 32'sh8000_0000;
      else sat34 = x[DataW-1:0];
    end
  endfunction

  // symmetric clamp against an unsigned limit
  function automatic logic signed [DataW-1:0] clampsym(input logic signed [DataW-1:0] x,
                                                       input logic [DataW-2:0] lim);
    logic signed [DataW:0] xl;
    logic signed [DataW:0] pl;
    logic signed [DataW:0] nl;
    begin
      xl = {x[DataW-1], x};
      pl = $signed({2'b00, lim});
      nl = -pl;
      if (xl > pl) clampsym = pl[DataW-1:0];
      else if (xl < nl) clampsym = nl[DataW-1:0];
      else clampsym = x;
    end
  endfunction

endpackage

// ----- rtl/cpmsc_mul.sv -----
// ----------------------------------------------------------------------------
// cpmsc_mul: digit-serial fixed-point multiplier
// Signed x unsigned, four gain bits per cycle, floor shift and saturation.
// ----------------------------------------------------------------------------
module cpmsc_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cpmsc_pkg::mul_req_t req,
  output cpmsc_pkg::mul_rsp_t rsp
);
  localparam int unsigned DigW  = 4;
  localparam int unsigned Steps = cpmsc_pkg::DataW / DigW;
  localparam int unsigned AccW  = 2 * cpmsc_pkg::DataW;

  logic                             busy_r;
  logic                             fin_r;
  logic [$clog2(Steps)-1:0]         cnt_r;
  logic signed [AccW-1:0]           acc_r;
  logic signed [cpmsc_pkg::DataW-1:0] a_r;
  logic [cpmsc_pkg::DataW-1:0]      b_r;
  logic signed [cpmsc_pkg::DataW+DigW:0] part;
  logic signed [AccW-1:0]           acc_nxt;
  logic signed [AccW-1:0]           shr;

  assign part = (cpmsc_pkg::DataW+DigW+1)'(a_r) *
                $signed({1'b0, b_r[cpmsc_pkg::DataW-1 -: DigW]});
  assign acc_nxt = (acc_r <<< DigW) + AccW'(part);
  assign shr = acc_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        a_r    <= req.a;
        b_r    <= req.b;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        b_r   <= b_r << DigW;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(Steps))'(Steps - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = fin_r;
    if (shr > AccW'(64'sh7FFF_FFFF)) rsp.res = 32'sh7FFF_FFFF;
    else if (shr < -AccW'(64'sh8000_0000)) rsp.res = 32'sh8000_0000;
    else rsp.res = shr[cpmsc_pkg::DataW-1:0];
  end

endmodule

// ----- rtl/cpmsc_div.sv -----
// ----------------------------------------------------------------------------
// cpmsc_div: duty divider
// Restoring division of voltage*2^15 by 24 volts, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpmsc_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [cpmsc_pkg::DataW-1:0]  volt,
  output logic                                done,
  output logic signed [cpmsc_pkg::DutyW-1:0]  duty
);
  localparam int unsigned DW = 48;
  localparam int unsigned QW = cpmsc_pkg::DutyW;
  localparam logic [DW-1:0] DivTop = DW'(longint'(24) << (FRAC_BITS + QW - 1));

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [$clog2(QW)-1:0] cnt_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     dsr_r;
  logic [QW-1:0]     q_r;
  logic [cpmsc_pkg::DataW:0] mag;
  logic              ge;

  assign mag = volt[cpmsc_pkg::DataW-1] ? -{1'b1, volt} : {1'b0, volt};
  assign ge = rem_r >= dsr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= volt[cpmsc_pkg::DataW-1];
        rem_r  <= DW'(mag) << (QW - 1);
        dsr_r  <= DivTop;
        q_r    <= '0;
      end else if (busy_r) begin
        if (ge) rem_r <= rem_r - dsr_r;
        q_r   <= {q_r[QW-2:0], ge};
        dsr_r <= dsr_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(QW))'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign duty = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

// ----- rtl/cascaded_pi_motor_speed_current.sv -----
// ----------------------------------------------------------------------------
// cascaded_pi_motor_speed_current: cascaded speed/current pi drive
// Speed pi feeding current pi, duty output and back-emf speed estimate.
// ----------------------------------------------------------------------------
// sequence: with drive and ball on, four loop multiplies, the duty division (launch,
//   16 quotient bits, handoff) and two estimate multiplies; otherwise only the two
//   estimate multiplies
// occupancy: one item in flight, next beat taken the cycle after the result is
//   registered, later while out_tready stalls the result register
// reset: synchronous active low, clears the integrators, filters and estimates and loads register defaults
module cascaded_pi_motor_speed_current #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [21:0] current_sample, upper bits zero
  input  logic [1:0]  in_tuser,   // [0] motor_enable, [1] ball_present
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] duty_command
  output logic [1:0]  out_tuser,  // [0] drive_valid, [1] speed_reached
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cpmsc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cpmsc_pkg::CfgDataW-1:0] cfg_data
);
  localparam int unsigned DW = cpmsc_pkg::DataW;
  // rounded physical constants in the chosen fixed-point format
  localparam logic [DW-2:0] KVmax = (DW-1)'(((longint'(239) << FRAC_BITS) + 5) / 10);
  localparam logic [DW-1:0] KRes  = DW'(((longint'(228) << FRAC_BITS) + 5) / 10);
  localparam logic [DW-1:0] KKv   = DW'(((longint'(2806) << FRAC_BITS) + 50) / 100);

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_DIV, S_FLT, S_M5, S_M6, S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [cpmsc_pkg::GainW-1:0] skp_r, ski_r, sil_r, cml_r, ckp_r, cki_r, cil_r;
  logic [cpmsc_pkg::TgtW-1:0]  tgt_r;

  // loop state
  logic signed [DW-1:0] si_r, ci_r, vc_r, va_r, es_r, sc_r, oe_r, err_r;
  logic signed [cpmsc_pkg::RawW-1:0] raw_r;
  logic en_r, ball_r, reached_r;
  logic signed [cpmsc_pkg::DutyW-1:0] duty_r;

  // output register
  logic        ov_r;
  logic [15:0] od_r;
  logic [1:0]  ou_r;

  cpmsc_pkg::mul_req_t mreq;
  cpmsc_pkg::mul_rsp_t mrsp;
  logic div_start, div_done;
  logic div_busy_q;
  logic signed [cpmsc_pkg::DutyW-1:0] div_q;

  cpmsc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp)
  );

  cpmsc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .volt(vc_r),
    .done(div_done), .duty(div_q)
  );

  // combinational step values
  logic signed [DW-1:0] err1, cmd, err2, si_nxt, ci_nxt, vc_nxt;
  logic signed [DW-1:0] va_nxt, sgn_diff, sc_nxt, bemf, oe_nxt;
  logic signed [DW:0]   va_sum, oe_sum;
  logic signed [37:0]   t20;
  logic signed [37:0]   tgt19, tgt21;
  logic                 reached_nxt;

  always_comb begin
    err1   = cpmsc_pkg::sat34(34'($signed({1'b0, tgt_r})) - 34'(es_r));
    si_nxt = cpmsc_pkg::clampsym(cpmsc_pkg::sat34(34'(si_r) + 34'(mrsp.res)),
                                 (DW-1)'(sil_r));
    cmd    = cpmsc_pkg::clampsym(cpmsc_pkg::sat34(34'(mrsp.res) + 34'(si_r)),
                                 (DW-1)'(cml_r));
    err2   = cpmsc_pkg::sat34(34'(cmd) - 34'(sc_r));
    ci_nxt = cpmsc_pkg::clampsym(cpmsc_pkg::sat34(34'(ci_r) + 34'(mrsp.res)),
                                 (DW-1)'(cil_r));
    vc_nxt = cpmsc_pkg::clampsym(cpmsc_pkg::sat34(34'(mrsp.res) + 34'(ci_r)), KVmax);
    // averages floor-halve a 33-bit sum
    va_sum   = (DW+1)'(vc_r) + (DW+1)'(va_r);
    va_nxt   = va_sum[DW:1];
    sgn_diff = cpmsc_pkg::sat34(34'(raw_r) - 34'(oe_r));
    sc_nxt   = (va_nxt < 0) ? cpmsc_pkg::sat34(-34'(sgn_diff)) : sgn_diff;
    bemf     = cpmsc_pkg::sat34(34'(vc_r) - 34'(mrsp.res));
    oe_sum   = (DW+1)'(raw_r) + (DW+1)'(oe_r);
    oe_nxt   = oe_sum[DW:1];
    // within 5% of target: 20*speed against 19 and 21 times target
    t20   = (38'(mrsp.res) <<< 4) + (38'(mrsp.res) <<< 2);
    tgt19 = $signed({12'd0, tgt_r}) * 38'sd19;
    tgt21 = $signed({12'd0, tgt_r}) * 38'sd21;
    reached_nxt = (t20 > tgt19) && (t20 < tgt21);
  end

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skp_r <= 24'd410;
      ski_r <= 24'd819;
      sil_r <= 24'd9830;
      cml_r <= 24'd0;
      ckp_r <= 24'd819200;
      cki_r <= 24'd137626;
      cil_r <= 24'd917504;
      tgt_r <= 26'd29491200;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cpmsc_pkg::REG_SPEED_KP: skp_r <= cfg_data[23:0];
        cpmsc_pkg::REG_SPEED_KI: ski_r <= cfg_data[23:0];
        cpmsc_pkg::REG_SPEED_IL: sil_r <= cfg_data[23:0];
        cpmsc_pkg::REG_CMD_LIM:  cml_r <= cfg_data[23:0];
        cpmsc_pkg::REG_CUR_KP:   ckp_r <= cfg_data[23:0];
        cpmsc_pkg::REG_CUR_KI:   cki_r <= cfg_data[23:0];
        cpmsc_pkg::REG_CUR_IL:   cil_r <= cfg_data[23:0];
        cpmsc_pkg::REG_TARGET:   tgt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // multiplier and divider launches
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = err1;
    mreq.b     = DW'(ski_r);
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        mreq.start = in_tvalid && in_tuser[0] && in_tuser[1];
      end
      S_M1: begin
        mreq.start = mrsp.done;
        mreq.a = err_r;
        mreq.b = DW'(skp_r);
      end
      S_M2: begin
        mreq.start = mrsp.done;
        mreq.a = err2;
        mreq.b = DW'(cki_r);
      end
      S_M3: begin
        mreq.start = mrsp.done;
        mreq.a = err_r;
        mreq.b = DW'(ckp_r);
      end
      S_FLT: begin
        mreq.start = 1'b1;
        mreq.a = sc_nxt;
        mreq.b = KRes;
      end
      S_M5: begin
        mreq.start = mrsp.done;
        mreq.a = bemf;
        mreq.b = KKv;
      end
      S_DIV: ;
      S_M4: ;
      S_M6: ;
      S_OUT: ;
      default: ;
    endcase
    // divider starts the cycle after the voltage is registered
    div_start = (state_r == S_DIV) && !mrsp.done && !div_busy_q;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ov_r       <= 1'b0;
      div_busy_q <= 1'b0;
      si_r <= '0; ci_r <= '0; vc_r <= '0; va_r <= '0;
      es_r <= '0; sc_r <= '0; oe_r <= '0;
      reached_r <= 1'b0;
    end else begin
      if (ov_r && out_tready && state_r != S_OUT) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            raw_r  <= $signed(in_tdata[cpmsc_pkg::RawW-1:0]);
            en_r   <= in_tuser[0];
            ball_r <= in_tuser[1];
            duty_r <= '0;
            err_r  <= err1;
            if (in_tuser[0] && in_tuser[1]) begin
              state_r <= S_M1;
            end else begin
              if (in_tuser[0]) vc_r <= '0;
              state_r <= S_FLT;
            end
          end
        end
        S_M1: if (mrsp.done) begin
          si_r <= si_nxt;
          state_r <= S_M2;
        end
        S_M2: if (mrsp.done) begin
          err_r <= err2;
          state_r <= S_M3;
        end
        S_M3: if (mrsp.done) begin
          ci_r <= ci_nxt;
          state_r <= S_M4;
        end
        S_M4: if (mrsp.done) begin
          vc_r <= vc_nxt;
          div_busy_q <= 1'b0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_start) div_busy_q <= 1'b1;
          if (div_done) begin
            duty_r <= div_q;
            div_busy_q <= 1'b0;
            state_r <= S_FLT;
          end
        end
        S_FLT: begin
          va_r <= va_nxt;
          sc_r <= sc_nxt;
          state_r <= S_M5;
        end
        S_M5: if (mrsp.done) state_r <= S_M6;
        S_M6: if (mrsp.done) begin
          es_r <= mrsp.res;
          reached_r <= reached_nxt;
          if (!ball_r) oe_r <= oe_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!ov_r || out_tready) begin
            ov_r <= 1'b1;
            od_r <= duty_r;
            ou_r <= {reached_r, en_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // the shared multiplier is never running while a new item can enter
  a_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mrsp.busy) else $error("multiplier busy in idle");

  // no duty without a duty command issued
  a_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 16'd0) else $error("duty without drive");

  // an item without drive and ball skips the loops
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !(in_tuser[0] && in_tuser[1]) |=> state_r == S_FLT)
    else $error("loop ran without drive and ball");

endmodule

// ----- test/tb_cascaded_pi_motor_speed_current.sv -----
// ----------------------------------------------------------------------------
// tb_cascaded_pi_motor_speed_current: self-checking bench for the pi drive
// Drives control ticks on the input stream, predicts each duty/flag beat in
// fixed point and compares beat by beat, across several register settings.
// ----------------------------------------------------------------------------
module tb_cascaded_pi_motor_speed_current;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frac = 16;
  localparam longint VMax  = ((239 <<< Frac) + 5) / 10;
  localparam longint RWind = ((228 <<< Frac) + 5) / 10;
  localparam longint KVolt = ((2806 <<< Frac) + 50) / 100;
  localparam int NumRand = 1500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cpmsc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [cpmsc_pkg::CfgDataW-1:0] cfg_data = '0;

  cascaded_pi_motor_speed_current u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected result beat
  typedef struct packed {
    logic drive;
    logic signed [15:0] duty;
    logic reached;
  } drive_beat_t;

  // predictor state
  longint gain [8];
  int spd_int, cur_int, volt_cmd, volt_avg, est_spd, sgn_cur, offs;
  drive_beat_t drive_q[$];
  int errors = 0;
  int mode_send = 0, mode_recv = 0;
  bit hold_off = 0;

  function automatic int sat(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  // arithmetic shift of a signed value floors toward minus infinity
  function automatic int fx_mul(longint a, longint b);
    return sat((a * b) >>> Frac);
  endfunction

  function automatic int clamp_lim(int x, longint lim);
    if (x > lim) return int'(lim);
    if (x < -lim) return int'(-lim);
    return x;
  endfunction

  function automatic drive_beat_t control_tick(bit en, bit ball, logic [21:0] smp);
    drive_beat_t r;
    longint raw, t;
    int err, cmd, diff, bemf;
    raw = longint'($signed(smp));
    r = '0;
    if (en) begin
      r.drive = 1'b1;
      if (ball) begin
        err = sat(gain[cpmsc_pkg::REG_TARGET] - est_spd);
        spd_int = clamp_lim(sat(longint'(spd_int) +
                                fx_mul(gain[cpmsc_pkg::REG_SPEED_KI], err)),
                            gain[cpmsc_pkg::REG_SPEED_IL]);
        cmd = clamp_lim(sat(longint'(fx_mul(gain[cpmsc_pkg::REG_SPEED_KP], err)) + spd_int),
                        gain[cpmsc_pkg::REG_CMD_LIM]);
        err = sat(longint'(cmd) - sgn_cur);
        cur_int = clamp_lim(sat(longint'(cur_int) +
                                fx_mul(gain[cpmsc_pkg::REG_CUR_KI], err)),
                            gain[cpmsc_pkg::REG_CUR_IL]);
        volt_cmd = clamp_lim(sat(longint'(fx_mul(gain[cpmsc_pkg::REG_CUR_KP], err)) +
                                 cur_int),
                             VMax);
        // division truncates toward zero
        r.duty = 16'((longint'(volt_cmd) * 32768) / (longint'(24) <<< Frac));
      end else begin
        volt_cmd = 0;
      end
    end
    volt_avg = int'((longint'(volt_cmd) + volt_avg) >>> 1);
    diff = sat(raw - offs);
    sgn_cur = (volt_avg < 0) ? sat(-longint'(diff)) : diff;
    bemf = sat(longint'(volt_cmd) - fx_mul(RWind, sgn_cur));
    est_spd = fx_mul(KVolt, bemf);
    t = longint'(est_spd) * 20;
    r.reached = (t > gain[cpmsc_pkg::REG_TARGET] * 19) &&
                (t < gain[cpmsc_pkg::REG_TARGET] * 21);
    if (!ball) offs = int'((raw + offs) >>> 1);
    return r;
  endfunction

  task automatic reg_write(logic [cpmsc_pkg::CfgIdxW-1:0] idx,
                           logic [cpmsc_pkg::CfgDataW-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx < 8) gain[idx] = (idx == cpmsc_pkg::REG_TARGET) ? longint'(val)
                                                            : longint'(val[23:0]);
  endtask

  // one tick offered on the input stream; prediction made at acceptance
  task automatic send_tick(bit en, bit ball, logic [21:0] smp);
    int gap;
    int idle_pct;
    gap = 0;
    idle_pct = (mode_send == 1) ? 57 : 9;
    if (mode_send == 1 || mode_send == 3)
      while ($urandom_range(99) < idle_pct && gap < 20) begin
        @(negedge clk);
        gap++;
      end
    in_tuser = {ball, en};
    in_tdata = {2'b00, smp};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    drive_q.push_back(control_tick(en, ball, smp));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (drive_q.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    // idle margin after the last beat before the next phase
    repeat (100) @(negedge clk);
  endtask

  // receiver side, drives ready at the falling edge
  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (mode_recv == 2) out_tready <= ($urandom_range(99) >= 57);
    else if (mode_recv == 3) out_tready <= ($urandom_range(99) >= 9);
    else out_tready <= 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    drive_beat_t exp_b;
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat duty=%0d user=%b", out_tdata, out_tuser);
      end else begin
        exp_b = drive_q.pop_front();
        if (out_tuser[0] !== exp_b.drive || out_tdata !== exp_b.duty ||
            out_tuser[1] !== exp_b.reached) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp drive=%b duty=%0d reached=%b %s=%b duty=%0d reached=%b",
                     exp_b.drive, exp_b.duty, exp_b.reached, "got drive",
                     out_tuser[0], $signed(out_tdata), out_tuser[1]);
        end
      end
    end
  end

  // directed rows: enable, ball, sample, and a typed expectation where obvious
  typedef struct packed {
    bit en;
    bit ball;
    logic [21:0] smp;
    bit known;
    drive_beat_t res;
  } tick_row_t;

  tick_row_t table_rows [12] = '{
    '{1'b0, 1'b0, 22'd0,        1'b1, '{1'b0, 16'sd0, 1'b0}},  // drive off after reset
    '{1'b1, 1'b0, 22'd0,        1'b1, '{1'b1, 16'sd0, 1'b0}},  // enabled, no ball
    '{1'b1, 1'b0, 22'h1FFFFF,   1'b0, '0},                     // largest sample
    '{1'b1, 1'b0, 22'h200000,   1'b0, '0},                     // most negative sample
    '{1'b1, 1'b1, 22'd0,        1'b0, '0},
    '{1'b1, 1'b1, 22'h3FFFFF,   1'b0, '0},
    '{1'b0, 1'b1, 22'h100000,   1'b0, '0},                     // disabled with ball
    '{1'b1, 1'b1, 22'h0F0000,   1'b0, '0},
    '{1'b1, 1'b1, 22'h310000,   1'b0, '0},
    '{1'b0, 1'b0, 22'h2AAAAA,   1'b0, '0},
    '{1'b1, 1'b1, 22'h155555,   1'b0, '0},
    '{1'b1, 1'b1, 22'h000001,   1'b0, '0}
  };

  // register sets: current values with a command limit of 65536, all maxima, zeros, random
  task automatic load_set(int k);
    logic [cpmsc_pkg::CfgDataW-1:0] v;
    for (int i = 0; i < 8; i++) begin
      case (k)
        0: v = (i == cpmsc_pkg::REG_CMD_LIM) ? 26'd65536 : 26'(gain[i]);
        1: v = (i == cpmsc_pkg::REG_TARGET) ? 26'h3FFFFFF : 26'hFFFFFF;
        2: v = 26'd0;
        default: v = (i == cpmsc_pkg::REG_TARGET) ? 26'($urandom_range(65536000))
                   : 26'($urandom_range(24'hFFFFFF) >> $urandom_range(12));
      endcase
      reg_write(i[cpmsc_pkg::CfgIdxW-1:0], v);
    end
  endtask

  initial begin
    logic [21:0] smp;
    bit en, ball;
    gain = '{410, 819, 9830, 0, 819200, 137626, 917504, 29491200};
    {spd_int, cur_int, volt_cmd, volt_avg, est_spd, sgn_cur, offs} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (table_rows[i]) begin
      send_tick(table_rows[i].en, table_rows[i].ball, table_rows[i].smp);
      if (table_rows[i].known && drive_q[$] !== table_rows[i].res) begin
        errors++;
        if (errors <= 10) $display("row %0d predictor disagrees with table", i);
      end
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      mode_send = ph % 4;
      mode_recv = ph % 4;
      load_set(ph == 5 ? 0 : ph % 4);
      // bad index is ignored
      if (ph == 3) reg_write(4'd12, 26'h3FFFFFF);
      for (int n = 0; n < NumRand / 6; n++) begin
        if (ph == 2 && n == 30) hold_off = 1'b1;
        if (ph == 2 && n == 60) hold_off = 1'b0;
        en = ($urandom_range(9) != 0);
        ball = ($urandom_range(9) > 1);
        case ($urandom_range(3))
          0: smp = 22'($urandom);
          1: smp = 22'($urandom_range(131072)) - 22'd65536;
          2: smp = $urandom_range(1) ? 22'h1FFFFF : 22'h200000;
          default: smp = 22'($urandom_range(16384));
        endcase
        send_tick(en, ball, smp);
      end
      drain();
    end

    if (errors == 0 && drive_q.size() == 0) begin
      $display("[cascaded_pi_motor_speed_current] OK");
    end else begin
      $display("[cascaded_pi_motor_speed_current] ERROR");
    end
    $finish;
  end

  // hold-off counted in cycles while the sender keeps offering ticks
  initial begin
    wait (hold_off);
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #20ms;
    $display("[cascaded_pi_motor_speed_current] ERROR");
    $finish;
  end
endmodule

// ----- cascaded_pi_motor_speed_current.f -----
rtl/cpmsc_pkg.sv
rtl/cpmsc_mul.sv
rtl/cpmsc_div.sv
rtl/cascaded_pi_motor_speed_current.sv
test/tb_cascaded_pi_motor_speed_current.sv
